// ===== sv/bsf_pkg.sv =====
package bsf_pkg;

    // bitmap geometry
    localparam int WORD_COUNT = 64;
    localparam int WORD_BITS  = 64;
    localparam int WADDR_W    = $clog2(WORD_COUNT);
    localparam int WBIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W      = WADDR_W + WBIT_W;
    localparam int LEN_W      = IDX_W + 1;
    localparam logic [LEN_W-1:0] CAPACITY = LEN_W'(WORD_COUNT * WORD_BITS);
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    // operation codes
    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_TEST  = 3'd1;
    localparam logic [2:0] OP_FILL  = 3'd2;
    localparam logic [2:0] OP_COUNT = 3'd3;
    localparam logic [2:0] OP_FIND  = 3'd4;

    // input item
    typedef struct packed {
        logic [2:0]  operation;
        logic        bit_value;
        logic [11:0] bit_index;
        logic [12:0] range_size;
        logic [12:0] range_end;
    } t_req;

    // result item
    typedef struct packed {
        logic        ok;
        logic [12:0] result_value;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk;
        logic done;
    } t_sts;

    // index of the lowest set bit of a word
    function automatic logic [WBIT_W-1:0] low_index(input logic [WORD_BITS-1:0] x);
        logic [WBIT_W-1:0] n;
        n = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (x[i]) begin
                n = WBIT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/bsf_mem.sv =====
module bsf_mem
    import bsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [WADDR_W-1:0]   i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [WADDR_W-1:0]   i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0]  r_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_vld;
    logic [WORD_BITS-1:0]  r_rd_data;
    logic                  r_rd_vld;

    // word storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // per-word written flags, a word never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/bsf_dp.sv =====
module bsf_dp
    import bsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [LEN_W-1:0]     i_cfg_wr_data,
    input  t_req                 i_req,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_rd_en,
    output logic [WADDR_W-1:0]   o_rd_addr,
    output logic                 o_wr_en,
    output logic [WADDR_W-1:0]   o_wr_addr,
    output logic [WORD_BITS-1:0] o_wr_data,
    input  logic [WORD_BITS-1:0] i_rd_data,
    output t_rsp                 o_rsp
);

    logic [LEN_W-1:0]   r_len;
    logic [2:0]         r_op;
    logic               r_val;
    logic [WBIT_W-1:0]  r_lo;
    logic [WBIT_W-1:0]  r_hi;
    logic [WADDR_W-1:0] r_first;
    logic [WADDR_W-1:0] r_last;
    logic [LEN_W-1:0]   r_end;
    logic               r_ok;
    logic               r_walk;
    logic [WADDR_W-1:0] r_w;
    logic [LEN_W-1:0]   r_acc;
    logic               r_hit;
    t_rsp               r_rsp;

    logic [LEN_W-1:0]   len;
    logic [LEN_W:0]     fill_end;
    logic [LEN_W-1:0]   n_start;
    logic [LEN_W-1:0]   n_end;
    logic [LEN_W-1:0]   n_endm1;
    logic               n_ok;
    logic               n_walk;
    logic [WBIT_W-1:0]  lo;
    logic [WBIT_W-1:0]  hi;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] sel;
    logic               hit;
    t_rsp               n_rsp;

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_len <= i_cfg_wr_data;
        end
    end

    assign len      = (r_len > CAPACITY) ? CAPACITY : r_len;
    assign fill_end = {2'b00, i_req.bit_index} + {1'b0, i_req.range_size};

    // range check and word span of a new item
    always_comb begin
        n_start = {1'b0, i_req.bit_index};
        n_end   = {1'b0, i_req.bit_index} + 13'd1;
        n_ok    = 1'b0;
        n_walk  = 1'b0;
        case (i_req.operation)
            OP_SET, OP_TEST: begin
                n_ok   = n_start < len;
                n_walk = n_ok;
            end
            OP_FILL: begin
                n_end  = fill_end[LEN_W-1:0];
                n_ok   = fill_end <= {1'b0, len};
                n_walk = n_ok && (i_req.range_size != '0);
            end
            OP_COUNT: begin
                n_start = '0;
                n_end   = len;
                n_ok    = 1'b1;
                n_walk  = len != '0;
            end
            OP_FIND: begin
                n_end = i_req.range_end;
                if (n_start >= i_req.range_end) begin
                    n_ok = 1'b1;
                end else if (i_req.range_end <= len) begin
                    n_ok   = 1'b1;
                    n_walk = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    assign n_endm1 = n_end - 13'd1;

    // bit mask of the current word
    assign lo   = (r_w == r_first) ? r_lo : '0;
    assign hi   = (r_w == r_last) ? r_hi : WBIT_W'(WORD_BITS - 1);
    assign mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));
    assign sel  = (r_val ? i_rd_data : ~i_rd_data) & mask;
    assign hit  = (r_op == OP_FIND) && (sel != '0);

    // memory access
    assign o_rd_en   = i_cmd.load || i_cmd.step;
    assign o_rd_addr = i_cmd.load ? r_first : r_w + 1'b1;
    assign o_wr_en   = i_cmd.step && (r_op inside {OP_SET, OP_FILL});
    assign o_wr_addr = r_w;
    assign o_wr_data = (i_rd_data & ~mask) | ({WORD_BITS{r_val}} & mask);

    assign o_sts.walk = r_walk;
    assign o_sts.done = (r_w == r_last) || hit;

    // item registers and word walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_req.operation;
            r_val   <= i_req.bit_value;
            r_lo    <= n_start[WBIT_W-1:0];
            r_hi    <= n_endm1[WBIT_W-1:0];
            r_first <= n_start[IDX_W-1:WBIT_W];
            r_last  <= n_endm1[IDX_W-1:WBIT_W];
            r_end   <= n_end;
            r_ok    <= n_ok;
            r_walk  <= n_walk;
            r_acc   <= '0;
            r_hit   <= 1'b0;
        end
        if (i_cmd.load) begin
            r_w <= r_first;
        end
        if (i_cmd.step) begin
            r_w <= r_w + 1'b1;
            case (r_op)
                OP_TEST: begin
                    r_acc <= {{(LEN_W-1){1'b0}}, |(i_rd_data & mask)};
                end
                OP_COUNT: begin
                    r_acc <= r_acc + LEN_W'($countones(i_rd_data & mask));
                end
                OP_FIND: begin
                    if (hit) begin
                        r_acc <= {1'b0, r_w, low_index(sel)};
                        r_hit <= 1'b1;
                    end
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    // result value
    always_comb begin
        n_rsp.ok = r_ok;
        case (r_op)
            OP_TEST, OP_COUNT: n_rsp.result_value = r_acc;
            OP_FIND:           n_rsp.result_value = r_hit ? r_acc : r_end;
            default:           n_rsp.result_value = '0;
        endcase
        if (!r_ok) begin
            n_rsp.result_value = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== sv/bsf_ctrl.sv =====
module bsf_ctrl
    import bsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;

    // commands
    assign o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.load     = r_state == S_LOAD;
    assign o_cmd.step     = r_state == S_WALK;
    assign o_cmd.out_load = (r_state == S_FIN) && (!r_out_vld || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = i_sts.walk ? S_WALK : S_FIN;
            end
            S_WALK: begin
                if (i_sts.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (o_cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output item valid
    always_comb begin
        n_out_vld = r_out_vld && i_out_stall;
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_vld;

endmodule

// ===== sv/bitmap_set_fill_count_find.sv =====
// one result item per input item, after a walk over n words, n from 0 to 64
// set and test walk one word, fill its span, find up to the first match, count the length
// one item at a time, one word per walk cycle; a new item is taken once the last result is
// loaded into the output register; that takes longer while a result waits on i_out_stall
// reset (i_rst_n low, synchronous): bitmap reads as all zeros, bit_length is 4096,
// no item is pending
module bitmap_set_fill_count_find
    import bsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_rsp             o_out_item,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data
);

    t_cmd                 cmd;
    t_sts                 sts;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] rd_data;

    // control
    bsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    bsf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (i_in_item),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_rd_data     (rd_data),
        .o_rsp         (o_out_item)
    );

    // word memory
    bsf_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import bsf_pkg::*;

    // mirror of the bitmap store: predicts each result, checks results in order
    class bitmap_mirror;
        bit [WORD_BITS-1:0] words [WORD_COUNT];
        logic [LEN_W-1:0]   bit_length;
        t_rsp               pending_rsp [$];
        int unsigned        op_tally [8];
        int unsigned        accepted_ok;
        int unsigned        checked;
        int unsigned        mismatches;
        int unsigned        length_writes;

        function new();
            foreach (words[w]) begin
                words[w] = '0;
            end
            bit_length = LEN_RESET;
        endfunction

        function void write_length(logic [LEN_W-1:0] v);
            bit_length = v;
            length_writes++;
        endfunction

        // lengths above capacity saturate
        function int unsigned usable_bits();
            return (bit_length > CAPACITY) ? int'(CAPACITY) : int'(bit_length);
        endfunction

        function bit read_bit(int unsigned i);
            return words[i / WORD_BITS][i % WORD_BITS];
        endfunction

        // apply one accepted request and queue the result it must produce
        function void note_request(t_req r);
            int unsigned len;
            int unsigned idx;
            int unsigned size;
            int unsigned stop;
            int unsigned total;
            bit          hit;
            t_rsp        rsp;
            len  = usable_bits();
            idx  = r.bit_index;
            size = r.range_size;
            stop = r.range_end;
            rsp  = '0;
            hit  = 1'b0;
            op_tally[r.operation]++;
            case (r.operation)
                OP_SET: begin
                    if (idx < len) begin
                        words[idx / WORD_BITS][idx % WORD_BITS] = r.bit_value;
                        rsp.ok = 1'b1;
                    end
                end
                OP_TEST: begin
                    if (idx < len) begin
                        rsp.ok = 1'b1;
                        rsp.result_value = LEN_W'(read_bit(idx));
                    end
                end
                OP_FILL: begin
                    if (idx + size <= len) begin
                        for (int unsigned i = idx; i < idx + size; i++) begin
                            words[i / WORD_BITS][i % WORD_BITS] = r.bit_value;
                        end
                        rsp.ok = 1'b1;
                    end
                end
                OP_COUNT: begin
                    total = 0;
                    for (int unsigned i = 0; i < len; i++) begin
                        total += read_bit(i);
                    end
                    rsp.ok = 1'b1;
                    rsp.result_value = LEN_W'(total);
                end
                OP_FIND: begin
                    // empty range answers with its end before the length check
                    if (idx >= stop) begin
                        rsp.ok = 1'b1;
                        rsp.result_value = r.range_end;
                    end else if (stop <= len) begin
                        rsp.ok = 1'b1;
                        rsp.result_value = r.range_end;
                        for (int unsigned i = idx; i < stop && !hit; i++) begin
                            if (read_bit(i) == r.bit_value) begin
                                rsp.result_value = LEN_W'(i);
                                hit = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            if (rsp.ok) begin
                accepted_ok++;
            end
            pending_rsp.push_back(rsp);
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            mismatches++;
            if (mismatches <= 100) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, actual ok %0d value %0d",
                         $time, got.ok, got.result_value);
                return;
            end
            want = pending_rsp.pop_front();
            checked++;
            if (got.ok !== want.ok) begin
                report("ok", want.ok, got.ok);
            end
            if (got.result_value !== want.result_value) begin
                report("result_value", want.result_value, got.result_value);
            end
        endfunction
    endclass

    localparam int PHASE_ITEMS = 225;
    localparam int PHASES      = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             o_in_stall;
    t_req             in_item = '0;
    logic             o_out_valid;
    logic             out_stall = 1'b0;
    t_rsp             o_out_item;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    bitmap_mirror mirror = new();
    bit           calm = 1'b0;
    bit           long_hold = 1'b0;

    bitmap_set_fill_count_find i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // guard against a hung block
    initial begin
        #15_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // result side: random stall bursts, one long hold on request
    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // every accepted result goes to the mirror
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            mirror.check_result(o_out_item);
        end
    end

    function automatic t_req make_req(logic [2:0] op, logic val, int unsigned idx,
                                      int unsigned size, int unsigned stop);
        t_req r;
        r.operation  = op;
        r.bit_value  = val;
        r.bit_index  = 12'(idx);
        r.range_size = 13'(size);
        r.range_end  = 13'(stop);
        return r;
    endfunction

    // mostly well-formed requests with random content, some noise
    function automatic t_req random_request(int unsigned len);
        t_req        r;
        int unsigned pick;
        int unsigned room;
        int unsigned stop;
        r.operation  = 3'($urandom);
        r.bit_value  = 1'($urandom);
        r.bit_index  = 12'($urandom);
        r.range_size = 13'($urandom);
        r.range_end  = 13'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r.operation = (pick < 15) ? OP_SET : OP_TEST;
            if (len > 0 && $urandom_range(0, 9) != 0) begin
                r.bit_index = 12'($urandom_range(0, len - 1));
            end
        end else if (pick < 50) begin
            r.operation = OP_FILL;
            if (len > 0 && $urandom_range(0, 99) < 85) begin
                r.bit_index = 12'($urandom_range(0, len - 1));
                room = len - r.bit_index;
                if ($urandom_range(0, 9) < 7) begin
                    r.range_size = 13'($urandom_range(0, (room < 70) ? room : 70));
                end else begin
                    r.range_size = 13'($urandom_range(0, room));
                end
            end
        end else if (pick < 60) begin
            r.operation = OP_COUNT;
        end else if (pick < 90) begin
            r.operation = OP_FIND;
            if (len > 0 && $urandom_range(0, 99) < 85) begin
                stop = $urandom_range(1, len);
                r.range_end = 13'(stop);
                if ($urandom_range(0, 3) == 0) begin
                    r.bit_index = 12'($urandom_range((stop > 70) ? stop - 70 : 0, stop - 1));
                end else begin
                    r.bit_index = 12'($urandom_range(0, stop - 1));
                end
            end
        end
        return r;
    endfunction

    task automatic send(input t_req r);
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= r;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        mirror.note_request(r);
    endtask

    // lower valid and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (mirror.pending_rsp.size() != 0);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        drain();
        repeat (70) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        mirror.write_length(v);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [LEN_W-1:0] lens [PHASES];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full length, extremes and word boundaries
        write_length(LEN_RESET);
        send(make_req(OP_SET, 1'b1, 0, 0, 0));
        send(make_req(OP_SET, 1'b1, 4095, 0, 0));
        send(make_req(OP_TEST, 1'b0, 0, 0, 0));
        send(make_req(OP_TEST, 1'b0, 4095, 0, 0));
        send(make_req(OP_TEST, 1'b1, 1, 8191, 8191));
        send(make_req(OP_COUNT, 1'b0, 0, 0, 0));
        send(make_req(OP_FIND, 1'b1, 1, 0, 4096));
        send(make_req(OP_FIND, 1'b0, 0, 0, 4096));
        send(make_req(OP_FILL, 1'b1, 0, 4096, 0));
        send(make_req(OP_COUNT, 1'b0, 0, 0, 0));
        send(make_req(OP_FIND, 1'b0, 0, 0, 4096));
        send(make_req(OP_FILL, 1'b0, 4095, 2, 0));
        send(make_req(OP_FILL, 1'b0, 4095, 0, 0));
        send(make_req(OP_FILL, 1'b0, 64, 8191, 0));
        send(make_req(OP_FILL, 1'b0, 63, 66, 0));
        send(make_req(OP_FIND, 1'b0, 0, 0, 8191));
        send(make_req(OP_FIND, 1'b0, 200, 0, 100));
        send(make_req(OP_FIND, 1'b1, 4095, 0, 0));
        send(make_req(OP_COUNT, 1'b1, 4095, 8191, 8191));
        send(make_req(3'd5, 1'b1, 4095, 8191, 8191));
        send(make_req(3'd6, 1'b0, 0, 0, 0));
        send(make_req(3'd7, 1'b1, 1234, 77, 99));

        // directed: short length rejects, saturation, empty bitmap length
        write_length(13'd100);
        send(make_req(OP_SET, 1'b1, 100, 0, 0));
        send(make_req(OP_TEST, 1'b0, 99, 0, 0));
        send(make_req(OP_FIND, 1'b0, 0, 0, 101));
        send(make_req(OP_COUNT, 1'b0, 0, 0, 0));
        write_length(13'd8191);
        send(make_req(OP_SET, 1'b0, 4095, 0, 0));
        send(make_req(OP_COUNT, 1'b0, 0, 0, 0));
        write_length(13'd0);
        send(make_req(OP_FILL, 1'b1, 0, 0, 0));
        send(make_req(OP_FIND, 1'b1, 0, 0, 0));

        // random phases, each at its own length
        lens[0] = LEN_RESET;
        lens[1] = 13'd8191;
        lens[2] = 13'($urandom_range(1, 4095));
        lens[3] = 13'd64;
        lens[4] = 13'd0;
        lens[5] = 13'd4095;
        lens[6] = 13'd1;
        lens[7] = 13'($urandom_range(65, 4096));
        for (int p = 0; p < PHASES; p++) begin
            write_length(lens[p]);
            calm = (p == PHASES - 1);
            if (p == 1) begin
                long_hold = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 100) begin
                    drain();
                end
                send(random_request(mirror.usable_bits()));
            end
        end

        drain();
        repeat (80) @(posedge clk);
        $display("ran %0d requests: set %0d, test %0d, fill %0d, count %0d, find %0d, other %0d",
                 mirror.op_tally.sum(), mirror.op_tally[OP_SET], mirror.op_tally[OP_TEST],
                 mirror.op_tally[OP_FILL], mirror.op_tally[OP_COUNT], mirror.op_tally[OP_FIND],
                 mirror.op_tally[5] + mirror.op_tally[6] + mirror.op_tally[7]);
        $display("%0d accepted with ok, %0d results checked over %0d lengths, %0d mismatches",
                 mirror.accepted_ok, mirror.checked, mirror.length_writes, mirror.mismatches);
        if (mirror.mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bsf_pkg.sv
sv/bsf_mem.sv
sv/bsf_dp.sv
sv/bsf_ctrl.sv
sv/bitmap_set_fill_count_find.sv
dv/testbench.sv
